[rtl/vfmpg_pkg.sv]
// ----------------------------------------------------------------------------
// vfmpg_pkg
// Types and constants for the valve fire-mode pulse generator.
// ----------------------------------------------------------------------------
package vfmpg_pkg;

   localparam int PRESSURE_W   = 12;
   localparam int MODE_W       = 9;
   localparam int HELD_W       = 11;
   localparam int PHASE_W      = 9;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 12;

   localparam int PERIOD_BASE  = 500;
   localparam int PULSE_TICKS  = 300;
   localparam int MODE_MAX     = 400;
   localparam int HELD_MAX     = 2047;
   localparam int BURST_END1   = 300;
   localparam int BURST_LO2    = 400;
   localparam int BURST_HI2    = 700;
   localparam int BURST_LO3    = 800;
   localparam int BURST_HI3    = 1100;

   localparam logic [MODE_W-1:0]     MODE_CONTINUOUS = MODE_W'(0);
   localparam logic [MODE_W-1:0]     MODE_SINGLE     = MODE_W'(1);
   localparam logic [MODE_W-1:0]     MODE_BURST      = MODE_W'(2);

   localparam logic [CSR_INDEX_W-1:0] CSR_FIRE_MODE  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_SETPOINT   = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_HYSTERESIS = CSR_INDEX_W'(2);

   localparam logic [MODE_W-1:0]     FIRE_MODE_RESET  = MODE_W'(0);
   localparam logic [PRESSURE_W-1:0] SETPOINT_RESET   = PRESSURE_W'(400);
   localparam logic [PRESSURE_W-1:0] HYSTERESIS_RESET = PRESSURE_W'(200);

   typedef struct packed {
      logic                  trigger_held;
      logic [PRESSURE_W-1:0] pressure_sample;
   } req_type;

   typedef struct packed {
      logic valve_open;
      logic compressor_on;
   } rsp_type;

endpackage

[rtl/valve_fire_mode_pulse_generator.sv]
// ----------------------------------------------------------------------------
// valve_fire_mode_pulse_generator
// Per-tick valve pulse shaping by firing mode, plus compressor hysteresis.
// ----------------------------------------------------------------------------
// One tick is taken every clock unless a waiting result stalls the input. A
// tick passes an input register, then the result register that offers its
// result; the hold counter, wave phase and compressor state change as the tick
// leaves the input register. The result register lets a new tick in while a
// finished result waits. Mode changes are expected with the trigger released.
module valve_fire_mode_pulse_generator #(
   parameter int PERIOD_BASE = vfmpg_pkg::PERIOD_BASE,
   parameter int PULSE_TICKS = vfmpg_pkg::PULSE_TICKS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  vfmpg_pkg::req_type                     req_payload,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output vfmpg_pkg::rsp_type                     rsp_payload,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [vfmpg_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [vfmpg_pkg::CSR_DATA_W-1:0]       csr_data
);

   localparam int MW = vfmpg_pkg::MODE_W;
   localparam int PW = vfmpg_pkg::PRESSURE_W;
   localparam int HW = vfmpg_pkg::HELD_W;
   localparam int QW = vfmpg_pkg::PHASE_W;

   logic [MW-1:0]           fire_mode_ff;
   logic [PW-1:0]           setpoint_ff;
   logic [PW-1:0]           hysteresis_ff;

   logic                    in_valid_ff;
   vfmpg_pkg::req_type      in_data_ff;
   logic                    rsp_valid_ff;
   vfmpg_pkg::rsp_type      rsp_data_ff;

   logic [HW-1:0]           held_ticks_ff, held_ticks_in;
   logic [QW-1:0]           wave_phase_ff, wave_phase_in;
   logic                    comp_ff, comp_in;

   logic                    advance;
   logic [MW-1:0]           mode_clamp;
   logic [10:0]             period_raw;
   logic [QW-1:0]           period;
   logic [QW:0]             half;
   logic [QW-1:0]           phase_eff;
   logic [QW:0]             phase_inc;
   logic                    burst_open;
   logic                    valve_hold;
   logic                    valve;
   logic [PW:0]             upper;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   always_comb begin
      mode_clamp = (fire_mode_ff > MW'(vfmpg_pkg::MODE_MAX)) ?
                   MW'(vfmpg_pkg::MODE_MAX) : fire_mode_ff;
      period_raw = 11'(PERIOD_BASE) - {2'b00, mode_clamp};
      if (period_raw[10] || (period_raw == 11'd0)) begin
         period = QW'(1);
      end else begin
         period = period_raw[QW-1:0];
      end
      half      = ({1'b0, period} + (QW+1)'(1)) >> 1;
      phase_eff = (wave_phase_ff >= period) ? '0 : wave_phase_ff;
      phase_inc = {1'b0, phase_eff} + (QW+1)'(1);

      burst_open = (held_ticks_ff < HW'(vfmpg_pkg::BURST_END1)) ||
                   ((held_ticks_ff > HW'(vfmpg_pkg::BURST_LO2)) &&
                    (held_ticks_ff < HW'(vfmpg_pkg::BURST_HI2))) ||
                   ((held_ticks_ff > HW'(vfmpg_pkg::BURST_LO3)) &&
                    (held_ticks_ff < HW'(vfmpg_pkg::BURST_HI3)));

      if (fire_mode_ff == vfmpg_pkg::MODE_CONTINUOUS) begin
         valve_hold = 1'b1;
      end else if (fire_mode_ff == vfmpg_pkg::MODE_SINGLE) begin
         valve_hold = held_ticks_ff < HW'(PULSE_TICKS);
      end else if (fire_mode_ff == vfmpg_pkg::MODE_BURST) begin
         valve_hold = burst_open;
      end else begin
         valve_hold = {1'b0, phase_eff} < half;
      end

      if (in_data_ff.trigger_held) begin
         valve = valve_hold;
         held_ticks_in = (held_ticks_ff == HW'(vfmpg_pkg::HELD_MAX)) ?
                         held_ticks_ff : held_ticks_ff + HW'(1);
         wave_phase_in = (phase_inc >= {1'b0, period}) ? '0 : phase_inc[QW-1:0];
      end else begin
         valve = 1'b0;
         held_ticks_in = '0;
         wave_phase_in = '0;
      end

      upper = {1'b0, setpoint_ff} + {1'b0, hysteresis_ff};
      if (in_data_ff.pressure_sample < setpoint_ff) begin
         comp_in = 1'b1;
      end else if (comp_ff && ({1'b0, in_data_ff.pressure_sample} > upper)) begin
         comp_in = 1'b0;
      end else begin
         comp_in = comp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fire_mode_ff  <= vfmpg_pkg::FIRE_MODE_RESET;
         setpoint_ff   <= vfmpg_pkg::SETPOINT_RESET;
         hysteresis_ff <= vfmpg_pkg::HYSTERESIS_RESET;
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         held_ticks_ff <= '0;
         wave_phase_ff <= '0;
         comp_ff       <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               vfmpg_pkg::CSR_FIRE_MODE:  fire_mode_ff  <= csr_data[MW-1:0];
               vfmpg_pkg::CSR_SETPOINT:   setpoint_ff   <= csr_data[PW-1:0];
               vfmpg_pkg::CSR_HYSTERESIS: hysteresis_ff <= csr_data[PW-1:0];
               default: begin
               end
            endcase
         end
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff  <= 1'b1;
            held_ticks_ff <= held_ticks_in;
            wave_phase_ff <= wave_phase_in;
            comp_ff       <= comp_in;
         end else if (rsp_ready) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_data_ff <= req_payload;
      end
      if (advance) begin
         rsp_data_ff.valve_open    <= valve;
         rsp_data_ff.compressor_on <= comp_in;
      end
   end

endmodule

[test/tb_valve_fire_mode_pulse_generator.sv]
// ----------------------------------------------------------------------------
// tb_valve_fire_mode_pulse_generator
// Self-checking bench for the valve fire-mode pulse generator. Ticks are fed
// through a queue to a clocked driver. A clocked monitor compares each result
// transaction with the output of a cycle-free predictor of the valve and
// compressor logic. The run covers every firing mode, the threshold extremes,
// long holds and random sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_valve_fire_mode_pulse_generator;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int PHASE_TICKS    = 20;
   localparam int LONG_STALL     = 80;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   vfmpg_pkg::req_type                req_payload = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   vfmpg_pkg::rsp_type                rsp_payload;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [vfmpg_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [vfmpg_pkg::CSR_DATA_W-1:0]  csr_data = '0;

   // predictor copy of registers and state
   logic [vfmpg_pkg::MODE_W-1:0]      mode_reg     = vfmpg_pkg::FIRE_MODE_RESET;
   logic [vfmpg_pkg::PRESSURE_W-1:0]  setpoint_reg = vfmpg_pkg::SETPOINT_RESET;
   logic [vfmpg_pkg::PRESSURE_W-1:0]  band_reg     = vfmpg_pkg::HYSTERESIS_RESET;
   logic [vfmpg_pkg::HELD_W-1:0]      hold_count   = '0;
   logic [vfmpg_pkg::PHASE_W-1:0]     wave_pos     = '0;
   logic                              comp_running = 1'b0;

   vfmpg_pkg::req_type                tick_queue[$];
   vfmpg_pkg::rsp_type                expected_outputs[$];
   int                                send_idle_pct  = 0;
   int                                recv_stall_pct = 0;
   int                                long_stall_req = 0;
   int                                long_stall_seen = 0;
   int                                stall_left = 0;
   int                                idle_cycles = 0;
   int                                mismatch_count = 0;

   valve_fire_mode_pulse_generator DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic vfmpg_pkg::rsp_type predict_tick(input vfmpg_pkg::req_type tick);
      vfmpg_pkg::rsp_type out;
      int                 mode_eff;
      int                 period;
      int                 half;
      int                 pos;
      int                 t;
      out = '0;
      if (tick.pressure_sample < setpoint_reg) begin
         comp_running = 1'b1;
      end else if (comp_running &&
                   int'(tick.pressure_sample) > int'(setpoint_reg) + int'(band_reg)) begin
         comp_running = 1'b0;
      end
      if (tick.trigger_held) begin
         mode_eff = (mode_reg > vfmpg_pkg::MODE_MAX) ? vfmpg_pkg::MODE_MAX : int'(mode_reg);
         period = vfmpg_pkg::PERIOD_BASE - mode_eff;
         if (period < 1) period = 1;
         t = int'(hold_count);
         pos = (int'(wave_pos) >= period) ? 0 : int'(wave_pos);
         case (mode_reg)
            vfmpg_pkg::MODE_CONTINUOUS: out.valve_open = 1'b1;
            vfmpg_pkg::MODE_SINGLE:     out.valve_open = (t < vfmpg_pkg::PULSE_TICKS);
            vfmpg_pkg::MODE_BURST: begin
               out.valve_open = (t < vfmpg_pkg::BURST_END1) ||
                                (t > vfmpg_pkg::BURST_LO2 && t < vfmpg_pkg::BURST_HI2) ||
                                (t > vfmpg_pkg::BURST_LO3 && t < vfmpg_pkg::BURST_HI3);
            end
            default: begin
               half = (period + 1) / 2;
               out.valve_open = (pos < half);
            end
         endcase
         if (t < vfmpg_pkg::HELD_MAX) hold_count = hold_count + 1'b1;
         pos++;
         if (pos >= period) pos = 0;
         wave_pos = vfmpg_pkg::PHASE_W'(pos);
      end else begin
         hold_count = '0;
         wave_pos = '0;
      end
      out.compressor_on = comp_running;
      return out;
   endfunction

   // biased towards the two compressor thresholds
   function automatic logic [vfmpg_pkg::PRESSURE_W-1:0] pick_pressure();
      int p;
      case ($urandom_range(5))
         0: p = 0;
         1: p = 4095;
         2, 3: p = int'($urandom_range(4095));
         4: p = int'(setpoint_reg) + int'($urandom_range(6)) - 3;
         default: p = int'(setpoint_reg) + int'(band_reg) + int'($urandom_range(6)) - 3;
      endcase
      if (p < 0) p = 0;
      if (p > 4095) p = 4095;
      return vfmpg_pkg::PRESSURE_W'(p);
   endfunction

   task automatic queue_tick(input logic trig,
                             input logic [vfmpg_pkg::PRESSURE_W-1:0] pressure);
      vfmpg_pkg::req_type tick;
      tick.trigger_held = trig;
      tick.pressure_sample = pressure;
      tick_queue.push_back(tick);
   endtask

   task automatic queue_hold(input logic trig, input int n);
      repeat (n) queue_tick(trig, pick_pressure());
   endtask

   // wait until every tick has been answered, then let the pipeline empty
   task automatic settle();
      @(negedge clock);
      while (tick_queue.size() != 0 || req_valid || expected_outputs.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [vfmpg_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [vfmpg_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         vfmpg_pkg::CSR_FIRE_MODE:  mode_reg = value[vfmpg_pkg::MODE_W-1:0];
         vfmpg_pkg::CSR_SETPOINT:   setpoint_reg = value;
         vfmpg_pkg::CSR_HYSTERESIS: band_reg = value;
         default: ;
      endcase
   endtask

   task automatic write_mode(input logic [vfmpg_pkg::MODE_W-1:0] mode);
      write_csr(vfmpg_pkg::CSR_FIRE_MODE, {3'($urandom_range(7)), mode});
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_outputs.push_back(predict_tick(req_payload));
         end
         if (!req_valid || req_ready) begin
            if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_payload <= tick_queue.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor and receiver
   always @(posedge clock) begin
      vfmpg_pkg::rsp_type exp_out;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_outputs.size() == 0) begin
               $error("unexpected result transaction: valve_open %0b compressor_on %0b",
                      rsp_payload.valve_open, rsp_payload.compressor_on);
               mismatch_count++;
            end else begin
               exp_out = expected_outputs.pop_front();
               if (rsp_payload.valve_open !== exp_out.valve_open) begin
                  $error("valve_open: expected %0b, actual %0b",
                         exp_out.valve_open, rsp_payload.valve_open);
                  mismatch_count++;
               end
               if (rsp_payload.compressor_on !== exp_out.compressor_on) begin
                  $error("compressor_on: expected %0b, actual %0b",
                         exp_out.compressor_on, rsp_payload.compressor_on);
                  mismatch_count++;
               end
            end
         end
         if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_ready <= 1'b0;
         end else if (long_stall_seen != long_stall_req) begin
            long_stall_seen <= long_stall_req;
            stall_left <= LONG_STALL;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      int ticks_done;
      int target;
      int n;
      int roll;
      int phase;
      logic [vfmpg_pkg::MODE_W-1:0]     mode;
      logic [vfmpg_pkg::PRESSURE_W-1:0] sp;
      logic [vfmpg_pkg::PRESSURE_W-1:0] band;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: thresholds at reset values, continuous mode
      send_idle_pct = 6;
      recv_stall_pct = 6;
      queue_tick(1'b0, 12'd0);
      queue_tick(1'b1, 12'd4095);
      queue_tick(1'b1, 12'd399);
      queue_tick(1'b1, 12'd400);
      queue_tick(1'b1, 12'd600);
      queue_tick(1'b1, 12'd601);
      queue_tick(1'b0, 12'hAAA);
      queue_tick(1'b0, 12'h555);
      settle();
      write_csr(vfmpg_pkg::CSR_SETPOINT, 12'd0);
      write_csr(vfmpg_pkg::CSR_HYSTERESIS, 12'd0);
      queue_tick(1'b1, 12'd0);
      queue_tick(1'b1, 12'd1);
      queue_tick(1'b0, 12'd0);
      settle();
      write_csr(vfmpg_pkg::CSR_SETPOINT, 12'd4095);
      write_csr(vfmpg_pkg::CSR_HYSTERESIS, 12'd4095);
      write_csr(vfmpg_pkg::CSR_HYSTERESIS + 1'b1, 12'hFFF);
      write_mode(vfmpg_pkg::MODE_W'(511));
      queue_tick(1'b1, 12'd4094);
      queue_tick(1'b1, 12'd4095);
      queue_tick(1'b1, 12'd4095);
      queue_tick(1'b0, 12'd0);
      settle();
      write_mode(vfmpg_pkg::MODE_SINGLE);
      queue_hold(1'b1, 2);
      queue_hold(1'b0, 1);
      settle();
      write_mode(vfmpg_pkg::MODE_BURST);
      queue_hold(1'b1, 2);
      settle();
      // mode change with the trigger still held
      write_mode(vfmpg_pkg::MODE_W'(vfmpg_pkg::MODE_MAX));
      queue_hold(1'b1, 3);
      queue_hold(1'b0, 1);

      // one long hold: wave phase beyond a shortened period, single pulse end,
      // then the later burst windows
      settle();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      write_csr(vfmpg_pkg::CSR_SETPOINT, 12'd400);
      write_csr(vfmpg_pkg::CSR_HYSTERESIS, 12'd200);
      write_mode(vfmpg_pkg::MODE_W'(3));
      queue_hold(1'b0, 1);
      queue_hold(1'b1, 102);
      settle();
      write_mode(vfmpg_pkg::MODE_W'(vfmpg_pkg::MODE_MAX));
      queue_hold(1'b1, 4);
      settle();
      write_mode(vfmpg_pkg::MODE_SINGLE);
      queue_hold(1'b1, 196);
      settle();
      write_mode(vfmpg_pkg::MODE_BURST);
      queue_hold(1'b1, 800);
      queue_hold(1'b0, 2);

      // random phases
      ticks_done = 0;
      for (phase = 0; phase < 4; phase++) begin
         settle();
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
            default: begin send_idle_pct = 6; recv_stall_pct = 6; end
         endcase
         case ($urandom_range(6))
            0: mode = vfmpg_pkg::MODE_CONTINUOUS;
            1: mode = vfmpg_pkg::MODE_SINGLE;
            2: mode = vfmpg_pkg::MODE_BURST;
            3: mode = vfmpg_pkg::MODE_W'(3);
            4: mode = vfmpg_pkg::MODE_W'(vfmpg_pkg::MODE_MAX);
            5: mode = vfmpg_pkg::MODE_W'($urandom_range(511, vfmpg_pkg::MODE_MAX + 1));
            default: mode = vfmpg_pkg::MODE_W'($urandom_range(vfmpg_pkg::MODE_MAX, 3));
         endcase
         case ($urandom_range(3))
            0: sp = '0;
            1: sp = '1;
            2: sp = vfmpg_pkg::PRESSURE_W'($urandom_range(4095));
            default: sp = vfmpg_pkg::PRESSURE_W'($urandom_range(800, 200));
         endcase
         case ($urandom_range(3))
            0: band = '0;
            1: band = '1;
            2: band = vfmpg_pkg::PRESSURE_W'($urandom_range(4095));
            default: band = vfmpg_pkg::PRESSURE_W'($urandom_range(300));
         endcase
         write_mode(mode);
         write_csr(vfmpg_pkg::CSR_SETPOINT, sp);
         write_csr(vfmpg_pkg::CSR_HYSTERESIS, band);
         target = ticks_done + PHASE_TICKS;
         while (ticks_done < target) begin
            n = $urandom_range(3, 1);
            queue_hold(1'b0, n);
            ticks_done += n;
            roll = $urandom_range(99);
            if (roll < 80) n = $urandom_range(12, 1);
            else           n = $urandom_range(40, 12);
            queue_hold(1'b1, n);
            ticks_done += n;
         end
         if (phase == 0) long_stall_req++;
      end

      settle();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
